FILE: hw/rtl/exu_pkg.sv
`timescale 1ns / 1ps

package exu_pkg;

  // Operation codes, alphabetical, stack operations excluded
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_JMP = 6'd26, OP_LDA = 6'd27,
    OP_LDX = 6'd28, OP_LDY = 6'd29, OP_LSR = 6'd30, OP_NOP = 6'd31,
    OP_ORA = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_SBC = 6'd35,
    OP_SEC = 6'd36, OP_SED = 6'd37, OP_SEI = 6'd38, OP_STA = 6'd39,
    OP_STX = 6'd40, OP_STY = 6'd41, OP_TAX = 6'd42, OP_TAY = 6'd43,
    OP_TSX = 6'd44, OP_TXA = 6'd45, OP_TXS = 6'd46, OP_TYA = 6'd47
  } op_e;

  // Status bit positions
  localparam int unsigned FL_C = 0;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_U = 5;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_N = 7;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h20;

  // Decimal adjust constants
  localparam logic [3:0] BCD_LO_ADJ  = 4'h6;
  localparam logic [4:0] BCD_LO_MAX  = 5'h0A;
  localparam logic [8:0] BCD_HI_MAX  = 9'h0A0;
  localparam logic [9:0] BCD_HI_ADJ  = 10'h060;
  localparam logic [7:0] BCD_SUB_HI  = 8'h60;
  localparam logic [7:0] BCD_SUB_LO  = 8'h06;

  typedef struct packed {
    logic [5:0]        mode;
    logic [7:0]        operand;
    logic [15:0]       address;
    logic signed [7:0] rel_offset;
    logic [15:0]       pc_in;
    logic              acc_mode;
  } item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [15:0] next_pc;
    logic [1:0]  branch_cycles;
    logic        may_add_cycle;
    regs_t       regs;
  } result_t;

endpackage

FILE: hw/rtl/eight_bit_cpu_execute_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     in_valid_i / in_ready_o     mode, operand, address, rel_offset, pc_in, acc_mode
// output    out_valid_o / out_ready_i   write, next_pc, branch_cycles, may_add_cycle, regs
// config    cfg_we_i                    cfg_wdata_i (decimal_enable)
//
// One instruction per cycle while the output is not stalled: an accepted transaction is held in
// the input register, the execute logic runs on it there and loads the result register.
// Output valid comes from the result register, which follows the input register.
// A stalled output holds the result; the input register still takes one transaction.
// Reset clears A, X, Y, sets SP to 0xFD, flags to 0x20 and enables decimal mode.

module eight_bit_cpu_execute_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [5:0]        mode_i,
  input  logic [7:0]        operand_i,
  input  logic [15:0]       address_i,
  input  logic signed [7:0] rel_offset_i,
  input  logic [15:0]       pc_in_i,
  input  logic              acc_mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              write_enable_o,
  output logic [15:0]       write_address_o,
  output logic [7:0]        write_data_o,
  output logic [15:0]       next_pc_o,
  output logic [1:0]        branch_cycles_o,
  output logic              may_add_cycle_o,
  output logic [7:0]        acc_out_o,
  output logic [7:0]        x_out_o,
  output logic [7:0]        y_out_o,
  output logic [7:0]        sp_out_o,
  output logic [7:0]        flags_out_o
);

  exu_pkg::item_t   item_q;
  logic             item_valid_q;
  exu_pkg::regs_t   regs_q, regs_d;
  exu_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             dec_en_q;
  logic             advance;

  // Execute when the result register is free or being drained
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;

  // Hold the decimal enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      dec_en_q <= cfg_wdata_i;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.mode       <= mode_i;
      item_q.operand    <= operand_i;
      item_q.address    <= address_i;
      item_q.rel_offset <= rel_offset_i;
      item_q.pc_in      <= pc_in_i;
      item_q.acc_mode   <= acc_mode_i;
    end
  end

  exu_alu u_alu (
    .item_i   (item_q),
    .regs_i   (regs_q),
    .dec_en_i (dec_en_q),
    .regs_o   (regs_d),
    .res_o    (res_d)
  );

  // Advance architectural registers and the result register together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.a    <= '0;
      regs_q.x    <= '0;
      regs_q.y    <= '0;
      regs_q.sp   <= exu_pkg::SP_RESET;
      regs_q.p    <= exu_pkg::FLAGS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        regs_q      <= regs_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_enable_o  = res_q.write_enable;
  assign write_address_o = res_q.write_address;
  assign write_data_o    = res_q.write_data;
  assign next_pc_o       = res_q.next_pc;
  assign branch_cycles_o = res_q.branch_cycles;
  assign may_add_cycle_o = res_q.may_add_cycle;
  assign acc_out_o       = res_q.regs.a;
  assign x_out_o         = res_q.regs.x;
  assign y_out_o         = res_q.regs.y;
  assign sp_out_o        = res_q.regs.sp;
  assign flags_out_o     = res_q.regs.p;

  // The unused status bit never drops
  a_unused_flag_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.p[exu_pkg::FL_U])
    else $error("unused status bit cleared");

  // Architectural state moves only when a transaction executes
  a_regs_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(regs_q))
    else $error("registers changed without a transaction");

  // An executed transaction always shows up at the output
  a_advance_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && (res_q.regs == regs_q))
    else $error("result lost or out of step with registers");

  // No write means zero address and data
  a_no_write_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.write_enable) |->
      (res_q.write_address == 16'd0) && (res_q.write_data == 8'd0))
    else $error("write fields set without write enable");

  // The branch cycle field is never all ones
  a_branch_cycles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.branch_cycles != 2'd3))
    else $error("branch cycle count out of range");

endmodule

FILE: hw/rtl/exu_alu.sv
`timescale 1ns / 1ps

module exu_alu (
  input  exu_pkg::item_t   item_i,
  input  exu_pkg::regs_t   regs_i,
  input  logic             dec_en_i,
  output exu_pkg::regs_t   regs_o,
  output exu_pkg::result_t res_o
);

  logic [7:0] a, m, src, inv, shf, tmp;
  logic       c, dec, take;

  logic [8:0] adc_bin;
  logic [4:0] adc_lo_raw, adc_lo;
  logic [8:0] adc_su;
  logic [9:0] adc_t, adc_s;
  logic [8:0] sbc_bin;
  logic [4:0] sbc_lo;
  logic [7:0] sbc_dec;
  logic [15:0] br_tgt;

  assign a   = regs_i.a;
  assign m   = item_i.operand;
  assign c   = regs_i.p[exu_pkg::FL_C];
  assign dec = dec_en_i & regs_i.p[exu_pkg::FL_D];
  assign src = item_i.acc_mode ? a : m;
  assign inv = ~m;

  // Binary and decimal add
  assign adc_bin    = {1'b0, a} + {1'b0, m} + {8'd0, c};
  assign adc_lo_raw = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, c};
  assign adc_lo     = (adc_lo_raw >= exu_pkg::BCD_LO_MAX)
                    ? {1'b1, adc_lo_raw[3:0] + exu_pkg::BCD_LO_ADJ} : adc_lo_raw;
  assign adc_su     = {1'b0, a[7:4], 4'd0} + {1'b0, m[7:4], 4'd0} + {4'd0, adc_lo};
  assign adc_t      = (adc_su >= exu_pkg::BCD_HI_MAX)
                    ? {1'b0, adc_su} + exu_pkg::BCD_HI_ADJ : {1'b0, adc_su};
  assign adc_s      = {{2{a[7]}}, a[7:4], 4'd0} + {{2{m[7]}}, m[7:4], 4'd0}
                    + {5'd0, adc_lo};

  // Binary and decimal subtract
  assign sbc_bin = {1'b0, a} + {1'b0, inv} + {8'd0, c};
  assign sbc_lo  = {1'b0, a[3:0]} + {1'b0, inv[3:0]} + {4'd0, c};
  assign sbc_dec = sbc_bin[7:0] - (sbc_bin[8] ? 8'd0 : exu_pkg::BCD_SUB_HI)
                 - (sbc_lo[4] ? 8'd0 : exu_pkg::BCD_SUB_LO);

  // Branch target with sign-extended displacement
  assign br_tgt = item_i.pc_in + {{8{item_i.rel_offset[7]}}, item_i.rel_offset};

  always_comb begin
    regs_o = regs_i;
    res_o  = '0;
    res_o.next_pc = item_i.pc_in;
    take = 1'b0;
    shf  = '0;
    tmp  = '0;

    case (exu_pkg::op_e'(item_i.mode))
      exu_pkg::OP_ADC: begin
        res_o.may_add_cycle = 1'b1;
        if (dec) begin
          regs_o.a = adc_t[7:0];
          regs_o.p[exu_pkg::FL_C] = |adc_t[9:8];
          regs_o.p[exu_pkg::FL_Z] = (adc_bin[7:0] == 8'd0);
          regs_o.p[exu_pkg::FL_N] = adc_su[7];
          regs_o.p[exu_pkg::FL_V] = !((adc_s[9] == adc_s[8]) && (adc_s[8] == adc_s[7]));
        end else begin
          regs_o.a = adc_bin[7:0];
          regs_o.p[exu_pkg::FL_C] = adc_bin[8];
          regs_o.p[exu_pkg::FL_Z] = (adc_bin[7:0] == 8'd0);
          regs_o.p[exu_pkg::FL_N] = adc_bin[7];
          regs_o.p[exu_pkg::FL_V] = ~(a[7] ^ m[7]) & (a[7] ^ adc_bin[7]);
        end
      end
      exu_pkg::OP_SBC: begin
        res_o.may_add_cycle = 1'b1;
        regs_o.a = dec ? sbc_dec : sbc_bin[7:0];
        regs_o.p[exu_pkg::FL_C] = sbc_bin[8];
        regs_o.p[exu_pkg::FL_Z] = (sbc_bin[7:0] == 8'd0);
        regs_o.p[exu_pkg::FL_N] = sbc_bin[7];
        regs_o.p[exu_pkg::FL_V] = ~(a[7] ^ inv[7]) & (a[7] ^ sbc_bin[7]);
      end
      exu_pkg::OP_AND, exu_pkg::OP_EOR, exu_pkg::OP_ORA, exu_pkg::OP_LDA: begin
        res_o.may_add_cycle = 1'b1;
        case (exu_pkg::op_e'(item_i.mode))
          exu_pkg::OP_AND: tmp = a & m;
          exu_pkg::OP_EOR: tmp = a ^ m;
          exu_pkg::OP_ORA: tmp = a | m;
          default:         tmp = m;
        endcase
        regs_o.a = tmp;
        regs_o.p[exu_pkg::FL_Z] = (tmp == 8'd0);
        regs_o.p[exu_pkg::FL_N] = tmp[7];
      end
      exu_pkg::OP_ASL, exu_pkg::OP_LSR, exu_pkg::OP_ROL, exu_pkg::OP_ROR: begin
        case (exu_pkg::op_e'(item_i.mode))
          exu_pkg::OP_ASL: begin
            shf = {src[6:0], 1'b0};
            regs_o.p[exu_pkg::FL_C] = src[7];
          end
          exu_pkg::OP_LSR: begin
            shf = {1'b0, src[7:1]};
            regs_o.p[exu_pkg::FL_C] = src[0];
          end
          exu_pkg::OP_ROL: begin
            shf = {src[6:0], c};
            regs_o.p[exu_pkg::FL_C] = src[7];
          end
          default: begin
            shf = {c, src[7:1]};
            regs_o.p[exu_pkg::FL_C] = src[0];
          end
        endcase
        regs_o.p[exu_pkg::FL_Z] = (shf == 8'd0);
        regs_o.p[exu_pkg::FL_N] = shf[7];
        if (item_i.acc_mode) begin
          regs_o.a = shf;
        end else begin
          res_o.write_enable  = 1'b1;
          res_o.write_address = item_i.address;
          res_o.write_data    = shf;
        end
      end
      exu_pkg::OP_BCC: take = ~regs_i.p[exu_pkg::FL_C];
      exu_pkg::OP_BCS: take = regs_i.p[exu_pkg::FL_C];
      exu_pkg::OP_BEQ: take = regs_i.p[exu_pkg::FL_Z];
      exu_pkg::OP_BNE: take = ~regs_i.p[exu_pkg::FL_Z];
      exu_pkg::OP_BMI: take = regs_i.p[exu_pkg::FL_N];
      exu_pkg::OP_BPL: take = ~regs_i.p[exu_pkg::FL_N];
      exu_pkg::OP_BVS: take = regs_i.p[exu_pkg::FL_V];
      exu_pkg::OP_BVC: take = ~regs_i.p[exu_pkg::FL_V];
      exu_pkg::OP_BIT: begin
        regs_o.p[exu_pkg::FL_Z] = ((a & m) == 8'd0);
        regs_o.p[exu_pkg::FL_V] = m[6];
        regs_o.p[exu_pkg::FL_N] = m[7];
      end
      exu_pkg::OP_CLC: regs_o.p[exu_pkg::FL_C] = 1'b0;
      exu_pkg::OP_CLD: regs_o.p[exu_pkg::FL_D] = 1'b0;
      exu_pkg::OP_CLI: regs_o.p[exu_pkg::FL_I] = 1'b0;
      exu_pkg::OP_CLV: regs_o.p[exu_pkg::FL_V] = 1'b0;
      exu_pkg::OP_SEC: regs_o.p[exu_pkg::FL_C] = 1'b1;
      exu_pkg::OP_SED: regs_o.p[exu_pkg::FL_D] = 1'b1;
      exu_pkg::OP_SEI: regs_o.p[exu_pkg::FL_I] = 1'b1;
      exu_pkg::OP_CMP, exu_pkg::OP_CPX, exu_pkg::OP_CPY: begin
        case (exu_pkg::op_e'(item_i.mode))
          exu_pkg::OP_CMP: begin
            tmp = a;
            res_o.may_add_cycle = 1'b1;
          end
          exu_pkg::OP_CPX: tmp = regs_i.x;
          default:         tmp = regs_i.y;
        endcase
        regs_o.p[exu_pkg::FL_C] = (tmp >= m);
        regs_o.p[exu_pkg::FL_Z] = (tmp == m);
        shf = tmp - m;
        regs_o.p[exu_pkg::FL_N] = shf[7];
      end
      exu_pkg::OP_DEC, exu_pkg::OP_INC: begin
        tmp = (exu_pkg::op_e'(item_i.mode) == exu_pkg::OP_DEC) ? m - 8'd1 : m + 8'd1;
        regs_o.p[exu_pkg::FL_Z] = (tmp == 8'd0);
        regs_o.p[exu_pkg::FL_N] = tmp[7];
        res_o.write_enable  = 1'b1;
        res_o.write_address = item_i.address;
        res_o.write_data    = tmp;
      end
      exu_pkg::OP_DEX, exu_pkg::OP_INX, exu_pkg::OP_LDX, exu_pkg::OP_TAX,
      exu_pkg::OP_TSX: begin
        case (exu_pkg::op_e'(item_i.mode))
          exu_pkg::OP_DEX: tmp = regs_i.x - 8'd1;
          exu_pkg::OP_INX: tmp = regs_i.x + 8'd1;
          exu_pkg::OP_LDX: begin
            tmp = m;
            res_o.may_add_cycle = 1'b1;
          end
          exu_pkg::OP_TAX: tmp = a;
          default:         tmp = regs_i.sp;
        endcase
        regs_o.x = tmp;
        regs_o.p[exu_pkg::FL_Z] = (tmp == 8'd0);
        regs_o.p[exu_pkg::FL_N] = tmp[7];
      end
      exu_pkg::OP_DEY, exu_pkg::OP_INY, exu_pkg::OP_LDY, exu_pkg::OP_TAY: begin
        case (exu_pkg::op_e'(item_i.mode))
          exu_pkg::OP_DEY: tmp = regs_i.y - 8'd1;
          exu_pkg::OP_INY: tmp = regs_i.y + 8'd1;
          exu_pkg::OP_LDY: begin
            tmp = m;
            res_o.may_add_cycle = 1'b1;
          end
          default:         tmp = a;
        endcase
        regs_o.y = tmp;
        regs_o.p[exu_pkg::FL_Z] = (tmp == 8'd0);
        regs_o.p[exu_pkg::FL_N] = tmp[7];
      end
      exu_pkg::OP_TXA, exu_pkg::OP_TYA: begin
        tmp = (exu_pkg::op_e'(item_i.mode) == exu_pkg::OP_TXA) ? regs_i.x : regs_i.y;
        regs_o.a = tmp;
        regs_o.p[exu_pkg::FL_Z] = (tmp == 8'd0);
        regs_o.p[exu_pkg::FL_N] = tmp[7];
      end
      exu_pkg::OP_TXS: regs_o.sp = regs_i.x;
      exu_pkg::OP_JMP: res_o.next_pc = item_i.address;
      exu_pkg::OP_STA, exu_pkg::OP_STX, exu_pkg::OP_STY: begin
        res_o.write_enable  = 1'b1;
        res_o.write_address = item_i.address;
        case (exu_pkg::op_e'(item_i.mode))
          exu_pkg::OP_STA: res_o.write_data = a;
          exu_pkg::OP_STX: res_o.write_data = regs_i.x;
          default:         res_o.write_data = regs_i.y;
        endcase
      end
      exu_pkg::OP_NOP: ;
      default: ;
    endcase

    // Redirect on a taken branch; a page cross gives the larger branch cycle count
    if (take) begin
      res_o.next_pc       = br_tgt;
      res_o.branch_cycles = (br_tgt[15:8] != item_i.pc_in[15:8]) ? 2'd2 : 2'd1;
    end

    res_o.regs = regs_o;
  end

endmodule

FILE: tb/eight_bit_cpu_execute_unit_tb.sv
`timescale 1ns / 1ps

module eight_bit_cpu_execute_unit_tb;

  localparam logic [5:0] MODE_UNUSED_LO = 6'd48;
  localparam logic [5:0] MODE_UNUSED_HI = 6'd63;
  localparam int unsigned RANDOM_PER_PHASE = 200;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Execute unit model and result checker
  class execute_scoreboard;
    logic [7:0] acc_reg;
    logic [7:0] x_reg;
    logic [7:0] y_reg;
    logic [7:0] sp_reg;
    logic [7:0] p_reg;
    bit         decimal_en;
    exu_pkg::result_t expected_results[$];
    int unsigned errors;
    int unsigned instrs_seen;
    int unsigned results_checked;
    int unsigned decimal_ops;
    int unsigned branches_taken;

    function new();
      acc_reg    = '0;
      x_reg      = '0;
      y_reg      = '0;
      sp_reg     = exu_pkg::SP_RESET;
      p_reg      = exu_pkg::FLAGS_RESET;
      decimal_en = 1'b1;
    endfunction

    // Update Z and N from a byte and pass it through
    function logic [7:0] set_zn(logic [7:0] v);
      p_reg[exu_pkg::FL_Z] = (v == 8'h00);
      p_reg[exu_pkg::FL_N] = v[7];
      return v;
    endfunction

    function int high_digit_signed(logic [7:0] v);
      int h;
      h = int'(v & 8'hF0);
      if (h >= 128) h -= 256;
      return h;
    endfunction

    function void add_with_carry(logic [7:0] m, bit dec);
      logic [8:0] sum;
      bit c;
      int lo, hi_sum, adj, s;
      c   = p_reg[exu_pkg::FL_C];
      sum = {1'b0, acc_reg} + {1'b0, m} + {8'd0, c};
      if (!dec) begin
        p_reg[exu_pkg::FL_V] = (acc_reg[7] == m[7]) && (acc_reg[7] != sum[7]);
        p_reg[exu_pkg::FL_C] = sum[8];
        acc_reg = set_zn(sum[7:0]);
        return;
      end
      // Adjust each digit; N and V come from the unadjusted high sum
      lo = int'(acc_reg[3:0]) + int'(m[3:0]) + int'(c);
      if (lo >= 10) lo = ((lo + 6) & 15) + 16;
      hi_sum = int'(acc_reg & 8'hF0) + int'(m & 8'hF0) + lo;
      adj = hi_sum;
      if (adj >= 'hA0) adj += 'h60;
      s = high_digit_signed(acc_reg) + high_digit_signed(m) + lo;
      acc_reg = adj[7:0];
      p_reg[exu_pkg::FL_C] = (adj >= 256);
      p_reg[exu_pkg::FL_Z] = (sum[7:0] == 8'h00);
      p_reg[exu_pkg::FL_N] = hi_sum[7];
      p_reg[exu_pkg::FL_V] = (s < -128) || (s > 127);
    endfunction

    function void subtract_with_borrow(logic [7:0] m, bit dec);
      logic [7:0] inv;
      logic [8:0] sum;
      bit c;
      int res;
      c   = p_reg[exu_pkg::FL_C];
      inv = ~m;
      sum = {1'b0, acc_reg} + {1'b0, inv} + {8'd0, c};
      res = int'(sum);
      if (dec) begin
        res = int'(acc_reg) - int'(m) + int'(c) - 1;
        if (int'(acc_reg) + int'(c) < int'(m) + 1) res -= 'h60;
        if (int'(acc_reg[3:0]) + int'(c) < int'(m[3:0]) + 1) res -= 'h06;
      end
      // Flags always follow the binary difference
      p_reg[exu_pkg::FL_V] = (acc_reg[7] == inv[7]) && (acc_reg[7] != sum[7]);
      p_reg[exu_pkg::FL_C] = sum[8];
      void'(set_zn(sum[7:0]));
      acc_reg = res[7:0];
    endfunction

    function void compare_reg(logic [7:0] r, logic [7:0] m);
      logic [7:0] d;
      d = r - m;
      p_reg[exu_pkg::FL_C] = (r >= m);
      p_reg[exu_pkg::FL_Z] = (r == m);
      p_reg[exu_pkg::FL_N] = d[7];
    endfunction

    // Advance the model by one accepted instruction and queue its result
    function void note_instr(exu_pkg::item_t it);
      exu_pkg::result_t r;
      logic [7:0]  m, src, sh;
      logic [15:0] tgt;
      bit dec, cin, is_branch, take;
      r = '0;
      r.next_pc = it.pc_in;
      m   = it.operand;
      cin = p_reg[exu_pkg::FL_C];
      dec = decimal_en && p_reg[exu_pkg::FL_D];
      src = it.acc_mode ? acc_reg : m;
      is_branch = 1'b0;
      take = 1'b0;
      instrs_seen++;
      case (it.mode)
        exu_pkg::OP_ADC: begin
          add_with_carry(m, dec);
          r.may_add_cycle = 1'b1;
          if (dec) decimal_ops++;
        end
        exu_pkg::OP_SBC: begin
          subtract_with_borrow(m, dec);
          r.may_add_cycle = 1'b1;
          if (dec) decimal_ops++;
        end
        exu_pkg::OP_AND: begin acc_reg = set_zn(acc_reg & m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_EOR: begin acc_reg = set_zn(acc_reg ^ m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_ORA: begin acc_reg = set_zn(acc_reg | m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_ASL, exu_pkg::OP_LSR, exu_pkg::OP_ROL, exu_pkg::OP_ROR: begin
          case (it.mode)
            exu_pkg::OP_ASL: begin p_reg[exu_pkg::FL_C] = src[7]; sh = {src[6:0], 1'b0}; end
            exu_pkg::OP_LSR: begin p_reg[exu_pkg::FL_C] = src[0]; sh = {1'b0, src[7:1]}; end
            exu_pkg::OP_ROL: begin p_reg[exu_pkg::FL_C] = src[7]; sh = {src[6:0], cin}; end
            default: begin p_reg[exu_pkg::FL_C] = src[0]; sh = {cin, src[7:1]}; end
          endcase
          sh = set_zn(sh);
          if (it.acc_mode) begin
            acc_reg = sh;
          end else begin
            r.write_enable  = 1'b1;
            r.write_address = it.address;
            r.write_data    = sh;
          end
        end
        exu_pkg::OP_BCC: begin is_branch = 1'b1; take = !p_reg[exu_pkg::FL_C]; end
        exu_pkg::OP_BCS: begin is_branch = 1'b1; take = p_reg[exu_pkg::FL_C]; end
        exu_pkg::OP_BEQ: begin is_branch = 1'b1; take = p_reg[exu_pkg::FL_Z]; end
        exu_pkg::OP_BMI: begin is_branch = 1'b1; take = p_reg[exu_pkg::FL_N]; end
        exu_pkg::OP_BNE: begin is_branch = 1'b1; take = !p_reg[exu_pkg::FL_Z]; end
        exu_pkg::OP_BPL: begin is_branch = 1'b1; take = !p_reg[exu_pkg::FL_N]; end
        exu_pkg::OP_BVC: begin is_branch = 1'b1; take = !p_reg[exu_pkg::FL_V]; end
        exu_pkg::OP_BVS: begin is_branch = 1'b1; take = p_reg[exu_pkg::FL_V]; end
        exu_pkg::OP_BIT: begin
          p_reg[exu_pkg::FL_Z] = ((acc_reg & m) == 8'h00);
          p_reg[exu_pkg::FL_V] = m[6];
          p_reg[exu_pkg::FL_N] = m[7];
        end
        exu_pkg::OP_CLC: p_reg[exu_pkg::FL_C] = 1'b0;
        exu_pkg::OP_CLD: p_reg[exu_pkg::FL_D] = 1'b0;
        exu_pkg::OP_CLI: p_reg[exu_pkg::FL_I] = 1'b0;
        exu_pkg::OP_CLV: p_reg[exu_pkg::FL_V] = 1'b0;
        exu_pkg::OP_SEC: p_reg[exu_pkg::FL_C] = 1'b1;
        exu_pkg::OP_SED: p_reg[exu_pkg::FL_D] = 1'b1;
        exu_pkg::OP_SEI: p_reg[exu_pkg::FL_I] = 1'b1;
        exu_pkg::OP_CMP: begin compare_reg(acc_reg, m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_CPX: compare_reg(x_reg, m);
        exu_pkg::OP_CPY: compare_reg(y_reg, m);
        exu_pkg::OP_DEC, exu_pkg::OP_INC: begin
          r.write_enable  = 1'b1;
          r.write_address = it.address;
          r.write_data    = set_zn((it.mode == exu_pkg::OP_INC) ? m + 8'd1 : m - 8'd1);
        end
        exu_pkg::OP_DEX: x_reg = set_zn(x_reg - 8'd1);
        exu_pkg::OP_DEY: y_reg = set_zn(y_reg - 8'd1);
        exu_pkg::OP_INX: x_reg = set_zn(x_reg + 8'd1);
        exu_pkg::OP_INY: y_reg = set_zn(y_reg + 8'd1);
        exu_pkg::OP_JMP: r.next_pc = it.address;
        exu_pkg::OP_LDA: begin acc_reg = set_zn(m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_LDX: begin x_reg = set_zn(m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_LDY: begin y_reg = set_zn(m); r.may_add_cycle = 1'b1; end
        exu_pkg::OP_STA, exu_pkg::OP_STX, exu_pkg::OP_STY: begin
          r.write_enable  = 1'b1;
          r.write_address = it.address;
          r.write_data    = (it.mode == exu_pkg::OP_STA) ? acc_reg :
                            (it.mode == exu_pkg::OP_STX) ? x_reg : y_reg;
        end
        exu_pkg::OP_TAX: x_reg = set_zn(acc_reg);
        exu_pkg::OP_TAY: y_reg = set_zn(acc_reg);
        exu_pkg::OP_TSX: x_reg = set_zn(sp_reg);
        exu_pkg::OP_TXA: acc_reg = set_zn(x_reg);
        exu_pkg::OP_TXS: sp_reg = x_reg;
        exu_pkg::OP_TYA: acc_reg = set_zn(y_reg);
        default: ;
      endcase

      // Taken branch: redirect and set the branch cycle count, larger on a page cross
      if (is_branch && take) begin
        tgt = it.pc_in + {{8{it.rel_offset[7]}}, it.rel_offset};
        r.branch_cycles = (tgt[15:8] != it.pc_in[15:8]) ? 2'd2 : 2'd1;
        r.next_pc = tgt;
        branches_taken++;
      end

      r.regs.a  = acc_reg;
      r.regs.x  = x_reg;
      r.regs.y  = y_reg;
      r.regs.sp = sp_reg;
      r.regs.p  = p_reg;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Match an output transaction against the oldest queued result
    function void check_result(exu_pkg::result_t got);
      exu_pkg::result_t want;
      if (expected_results.size() == 0) begin
        $error("result transaction with no instruction outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      compare_field("write_enable", 16'(want.write_enable), 16'(got.write_enable));
      compare_field("write_address", want.write_address, got.write_address);
      compare_field("write_data", 16'(want.write_data), 16'(got.write_data));
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("branch_cycles", 16'(want.branch_cycles), 16'(got.branch_cycles));
      compare_field("may_add_cycle", 16'(want.may_add_cycle), 16'(got.may_add_cycle));
      compare_field("acc_out", 16'(want.regs.a), 16'(got.regs.a));
      compare_field("x_out", 16'(want.regs.x), 16'(got.regs.x));
      compare_field("y_out", 16'(want.regs.y), 16'(got.regs.y));
      compare_field("sp_out", 16'(want.regs.sp), 16'(got.regs.sp));
      compare_field("flags_out", 16'(want.regs.p), 16'(got.regs.p));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [5:0]        mode = '0;
  logic [7:0]        operand = '0;
  logic [15:0]       address = '0;
  logic signed [7:0] rel_offset = '0;
  logic [15:0]       pc_in = '0;
  logic              acc_mode = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              write_enable;
  logic [15:0]       write_address;
  logic [7:0]        write_data;
  logic [15:0]       next_pc;
  logic [1:0]        branch_cycles;
  logic              may_add_cycle;
  logic [7:0]        acc_out;
  logic [7:0]        x_out;
  logic [7:0]        y_out;
  logic [7:0]        sp_out;
  logic [7:0]        flags_out;

  execute_scoreboard sb;
  bit steady = 1'b1;

  logic [5:0] arith_ops [2] = '{exu_pkg::OP_ADC, exu_pkg::OP_SBC};
  logic [5:0] flag_ops [4] = '{exu_pkg::OP_SED, exu_pkg::OP_CLD, exu_pkg::OP_SEC,
                               exu_pkg::OP_CLC};
  logic [5:0] branch_ops [8] = '{exu_pkg::OP_BCC, exu_pkg::OP_BCS, exu_pkg::OP_BEQ,
                                 exu_pkg::OP_BMI, exu_pkg::OP_BNE, exu_pkg::OP_BPL,
                                 exu_pkg::OP_BVC, exu_pkg::OP_BVS};

  eight_bit_cpu_execute_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .operand_i       (operand),
    .address_i       (address),
    .rel_offset_i    (rel_offset),
    .pc_in_i         (pc_in),
    .acc_mode_i      (acc_mode),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .write_enable_o  (write_enable),
    .write_address_o (write_address),
    .write_data_o    (write_data),
    .next_pc_o       (next_pc),
    .branch_cycles_o (branch_cycles),
    .may_add_cycle_o (may_add_cycle),
    .acc_out_o       (acc_out),
    .x_out_o         (x_out),
    .y_out_o         (y_out),
    .sp_out_o        (sp_out),
    .flags_out_o     (flags_out)
  );

  // Clock: 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample both handshakes; inputs are noted before outputs are checked
  always @(posedge clk) begin : monitor
    exu_pkg::item_t   seen;
    exu_pkg::result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.mode       = mode;
        seen.operand    = operand;
        seen.address    = address;
        seen.rel_offset = rel_offset;
        seen.pc_in      = pc_in;
        seen.acc_mode   = acc_mode;
        sb.note_instr(seen);
      end
      if (out_valid && out_ready) begin
        got.write_enable  = write_enable;
        got.write_address = write_address;
        got.write_data    = write_data;
        got.next_pc       = next_pc;
        got.branch_cycles = branch_cycles;
        got.may_add_cycle = may_add_cycle;
        got.regs.a        = acc_out;
        got.regs.x        = x_out;
        got.regs.y        = y_out;
        got.regs.sp       = sp_out;
        got.regs.p        = flags_out;
        sb.check_result(got);
      end
    end
  end

  // Result side: when not steady, stall a random number of cycles before each transaction
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic exu_pkg::item_t make_instr(logic [5:0] m, logic [7:0] opd,
                                                logic [15:0] addr, logic [7:0] rel,
                                                logic [15:0] pc, logic accm);
    exu_pkg::item_t it;
    it.mode       = m;
    it.operand    = opd;
    it.address    = addr;
    it.rel_offset = rel;
    it.pc_in      = pc;
    it.acc_mode   = accm;
    return it;
  endfunction

  // Bias toward decimal arithmetic, flag changes and branches
  function automatic exu_pkg::item_t random_instr();
    exu_pkg::item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) it.mode = arith_ops[$urandom_range(0, 1)];
    else if (pick < 32) it.mode = flag_ops[$urandom_range(0, 3)];
    else if (pick < 44) it.mode = branch_ops[$urandom_range(0, 7)];
    else if (pick < 48) it.mode = 6'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
    else it.mode = 6'($urandom_range(exu_pkg::OP_ADC, exu_pkg::OP_TYA));
    if ($urandom_range(0, 1))
      it.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    else
      it.operand = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: it.address = 16'h0000;
      1: it.address = 16'hFFFF;
      default: it.address = 16'($urandom_range(0, 65535));
    endcase
    it.rel_offset = 8'($urandom_range(0, 255));
    it.pc_in      = 16'($urandom_range(0, 65535));
    it.acc_mode   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Present one instruction, after a random gap when not steady, and hold it until accepted
  task automatic send_instr(exu_pkg::item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= it.mode;
    operand    <= it.operand;
    address    <= it.address;
    rel_offset <= it.rel_offset;
    pc_in      <= it.pc_in;
    acc_mode   <= it.acc_mode;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_decimal_enable(bit v);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.decimal_en = v;
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: decimal carries and borrows, overflow, branch wrap, edge operands
    steady = 1'b1;
    send_instr(make_instr(exu_pkg::OP_LDA, 8'h99, 16'h0000, 8'h00, 16'h0000, 1'b0));
    send_instr(make_instr(exu_pkg::OP_SED, 8'h00, 16'h0000, 8'h00, 16'h0001, 1'b0));
    send_instr(make_instr(exu_pkg::OP_ADC, 8'h01, 16'h0000, 8'h00, 16'h0002, 1'b0));
    send_instr(make_instr(exu_pkg::OP_ADC, 8'h58, 16'h0000, 8'h00, 16'h0004, 1'b0));
    send_instr(make_instr(exu_pkg::OP_LDA, 8'h00, 16'h0000, 8'h00, 16'h0006, 1'b0));
    send_instr(make_instr(exu_pkg::OP_SBC, 8'h01, 16'h0000, 8'h00, 16'h0008, 1'b0));
    send_instr(make_instr(exu_pkg::OP_SBC, 8'h12, 16'h0000, 8'h00, 16'h000A, 1'b0));
    send_instr(make_instr(exu_pkg::OP_ADC, 8'hFF, 16'h0000, 8'h00, 16'h000C, 1'b0));
    send_instr(make_instr(exu_pkg::OP_CLD, 8'h00, 16'h0000, 8'h00, 16'h000E, 1'b0));
    send_instr(make_instr(exu_pkg::OP_LDA, 8'h7F, 16'h0000, 8'h00, 16'h0010, 1'b0));
    send_instr(make_instr(exu_pkg::OP_ADC, 8'h01, 16'h0000, 8'h00, 16'h0012, 1'b0));
    send_instr(make_instr(exu_pkg::OP_SBC, 8'h80, 16'h0000, 8'h00, 16'h0014, 1'b0));
    send_instr(make_instr(exu_pkg::OP_BVS, 8'h00, 16'h0000, 8'h80, 16'h0010, 1'b0));
    send_instr(make_instr(exu_pkg::OP_SEC, 8'h00, 16'h0000, 8'h00, 16'h0020, 1'b0));
    send_instr(make_instr(exu_pkg::OP_BCS, 8'h00, 16'h0000, 8'h7F, 16'hFFF0, 1'b0));
    send_instr(make_instr(exu_pkg::OP_JMP, 8'h00, 16'hFFFF, 8'h00, 16'h0030, 1'b0));
    send_instr(make_instr(exu_pkg::OP_ASL, 8'hFF, 16'h1234, 8'h00, 16'h0032, 1'b1));
    send_instr(make_instr(exu_pkg::OP_ROR, 8'h01, 16'hFFFF, 8'h00, 16'h0034, 1'b0));
    send_instr(make_instr(exu_pkg::OP_INC, 8'hFF, 16'h0000, 8'h00, 16'h0036, 1'b0));
    send_instr(make_instr(exu_pkg::OP_DEC, 8'h00, 16'h8000, 8'h00, 16'h0038, 1'b0));
    send_instr(make_instr(exu_pkg::OP_LDX, 8'hFF, 16'h0000, 8'h00, 16'h003A, 1'b0));
    send_instr(make_instr(exu_pkg::OP_TXS, 8'h00, 16'h0000, 8'h00, 16'h003C, 1'b0));
    send_instr(make_instr(exu_pkg::OP_TSX, 8'h00, 16'h0000, 8'h00, 16'h003E, 1'b0));
    send_instr(make_instr(exu_pkg::OP_BIT, 8'hC0, 16'h0000, 8'h00, 16'h0040, 1'b0));
    send_instr(make_instr(exu_pkg::OP_CMP, 8'h00, 16'h0000, 8'h00, 16'h0042, 1'b0));
    send_instr(make_instr(exu_pkg::OP_CPY, 8'hFF, 16'h0000, 8'h00, 16'h0044, 1'b0));
    send_instr(make_instr(exu_pkg::OP_NOP, 8'hFF, 16'hFFFF, 8'h7F, 16'hFFFF, 1'b1));
    send_instr(make_instr(MODE_UNUSED_LO, 8'hAA, 16'h5555, 8'h80, 16'h0046, 1'b0));
    send_instr(make_instr(MODE_UNUSED_HI, 8'h55, 16'hAAAA, 8'h7F, 16'h0048, 1'b1));

    // Random phases, alternating the decimal enable between its extremes
    for (int ph = 0; ph < 4; ph++) begin
      set_decimal_enable(ph[0]);
      for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) begin
        steady = (i < 30);
        if (i == RANDOM_PER_PHASE / 2) wait_results_drained();
        send_instr(random_instr());
      end
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("eight_bit_cpu_execute_unit_tb: %0d instructions, %0d results checked",
             sb.instrs_seen, sb.results_checked);
    $display("eight_bit_cpu_execute_unit_tb: %0d decimal ADC/SBC, %0d taken branches",
             sb.decimal_ops, sb.branches_taken);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("eight_bit_cpu_execute_unit_tb: done, clean");
    end else begin
      $display("eight_bit_cpu_execute_unit_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("eight_bit_cpu_execute_unit_tb: done, errors");
    $finish;
  end

endmodule
